// File: src/tpa_pkg.sv
package tpa_pkg;

    // Width of every index, corner and count field.
    localparam int DATA_W = 32;

    // Default number of low index bits that are kept from each incoming item.
    localparam int INDEX_W_DEFAULT = 32;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PRIM_MODE  = 1'b0,
        REG_BASE_INDEX = 1'b1
    } cfg_reg_t;

    // Primitive modes.
    typedef enum logic [1:0] {
        MODE_LIST  = 2'd0,
        MODE_STRIP = 2'd1,
        MODE_FAN   = 2'd2,
        MODE_OTHER = 2'd3
    } prim_mode_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic [DATA_W-1:0] vertex;
        prim_mode_t        mode;
        logic              last;
    } q_entry_t;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

endpackage

// File: src/tpa_front.sv
module tpa_front #(
    parameter int INDEX_WIDTH = tpa_pkg::INDEX_W_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [tpa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tpa_pkg::DATA_W-1:0]        cfg_wdata,
    // Input item channel.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tpa_pkg::DATA_W-1:0]        s_axis_tdata,
    input  logic                              s_axis_tlast,
    // Queue write side.
    input  logic                              q_full,
    output logic                              q_push,
    output tpa_pkg::q_entry_t                 q_entry
);

    localparam logic [tpa_pkg::DATA_W-1:0] IDX_MASK =
        tpa_pkg::DATA_W'((64'd1 << INDEX_WIDTH) - 64'd1);

    tpa_pkg::prim_mode_t               prim_mode_reg;
    logic [tpa_pkg::DATA_W-1:0]        base_index_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prim_mode_reg  <= tpa_pkg::MODE_LIST;
            base_index_reg <= '0;
        end else if (cfg_we) begin
            unique case (tpa_pkg::cfg_reg_t'(cfg_addr))
                tpa_pkg::REG_PRIM_MODE: begin
                    prim_mode_reg <= tpa_pkg::prim_mode_t'(cfg_wdata[1:0]);
                end
                tpa_pkg::REG_BASE_INDEX: begin
                    base_index_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // An item is taken whenever the queue has room.
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Rebase the index and tag it with the mode that applies to it.
    always_comb begin
        q_entry.vertex = (s_axis_tdata & IDX_MASK) + base_index_reg;
        q_entry.mode   = prim_mode_reg;
        q_entry.last   = s_axis_tlast;
    end

endmodule

// File: src/tpa_queue.sv
module tpa_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tpa_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output tpa_pkg::q_head_t  head
);

    tpa_pkg::q_entry_t             mem [tpa_pkg::QUEUE_DEPTH];
    logic [tpa_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [tpa_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [tpa_pkg::QPTR_W:0]      count_reg;
    logic [tpa_pkg::QPTR_W:0]      count_next;

    assign full       = (count_reg == (tpa_pkg::QPTR_W + 1)'(tpa_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/tpa_back.sv
module tpa_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Queue read side.
    input  tpa_pkg::q_head_t               head,
    output logic                           pop,
    // Result item channel.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [4*tpa_pkg::DATA_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int W = tpa_pkg::DATA_W;

    // Assembly state.
    logic [W-1:0] held_first_reg,  held_first_next;
    logic [W-1:0] held_second_reg, held_second_next;
    logic [1:0]   seen_count_reg,  seen_count_next;
    logic [1:0]   list_phase_reg,  list_phase_next;
    logic         strip_parity_reg, strip_parity_next;
    logic [W-1:0] tally_reg,       tally_next;

    // Output register.
    logic         out_valid_reg,   out_valid_next;
    logic         out_tri_reg,     out_tri_next;
    logic [W-1:0] out_a_reg,       out_a_next;
    logic [W-1:0] out_b_reg,       out_b_next;
    logic [W-1:0] out_c_reg,       out_c_next;
    logic [W-1:0] out_count_reg,   out_count_next;
    logic         out_end_reg,     out_end_next;

    logic         tri_hit;
    logic [W-1:0] ca, cb, cc;
    logic [W-1:0] vtx;
    logic [W-1:0] tally_inc;

    // Take the next item when the output register is free or being emptied.
    assign pop = head.valid && (!out_valid_reg || m_axis_tready);
    assign vtx = head.entry.vertex;

    // Triangle forming for the item at the head of the queue.
    always_comb begin
        held_first_next   = held_first_reg;
        held_second_next  = held_second_reg;
        seen_count_next   = seen_count_reg;
        list_phase_next   = list_phase_reg;
        strip_parity_next = strip_parity_reg;
        tri_hit           = 1'b0;
        ca                = '0;
        cb                = '0;
        cc                = '0;

        unique case (head.entry.mode)
            tpa_pkg::MODE_LIST: begin
                if (list_phase_reg == 2'd0) begin
                    held_first_next = vtx;
                    list_phase_next = 2'd1;
                end else if (list_phase_reg == 2'd1) begin
                    held_second_next = vtx;
                    list_phase_next  = 2'd2;
                end else begin
                    tri_hit         = 1'b1;
                    ca              = held_first_reg;
                    cb              = held_second_reg;
                    cc              = vtx;
                    list_phase_next = 2'd0;
                end
            end
            tpa_pkg::MODE_STRIP: begin
                if (seen_count_reg == 2'd0) begin
                    held_first_next = vtx;
                    seen_count_next = 2'd1;
                end else if (seen_count_reg == 2'd1) begin
                    held_second_next = vtx;
                    seen_count_next  = 2'd2;
                end else begin
                    tri_hit = 1'b1;
                    // Odd triangles swap the first two corners to keep winding.
                    ca = strip_parity_reg ? held_second_reg : held_first_reg;
                    cb = strip_parity_reg ? held_first_reg : held_second_reg;
                    cc = vtx;
                    held_first_next   = held_second_reg;
                    held_second_next  = vtx;
                    strip_parity_next = !strip_parity_reg;
                end
            end
            tpa_pkg::MODE_FAN: begin
                if (seen_count_reg == 2'd0) begin
                    held_first_next = vtx;
                    seen_count_next = 2'd1;
                end else if (seen_count_reg == 2'd1) begin
                    held_second_next = vtx;
                    seen_count_next  = 2'd2;
                end else begin
                    tri_hit          = 1'b1;
                    ca               = held_first_reg;
                    cb               = held_second_reg;
                    cc               = vtx;
                    held_second_next = vtx;
                end
            end
            default: begin
                // Non-triangle mode consumes the index without effect.
            end
        endcase

        tally_inc  = tri_hit ? (tally_reg + 1'b1) : tally_reg;
        tally_next = tally_inc;

        // The last item of a set clears everything for the next set.
        if (head.entry.last) begin
            held_first_next   = '0;
            held_second_next  = '0;
            seen_count_next   = '0;
            list_phase_next   = '0;
            strip_parity_next = 1'b0;
            tally_next        = '0;
        end
    end

    // Output register loading.
    always_comb begin
        out_tri_next   = out_tri_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        out_c_next     = out_c_reg;
        out_count_next = out_count_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (pop && (tri_hit || head.entry.last)) begin
            out_valid_next = 1'b1;
            out_tri_next   = tri_hit;
            out_a_next     = ca;
            out_b_next     = cb;
            out_c_next     = cc;
            out_count_next = tally_inc;
            out_end_next   = head.entry.last;
        end
    end

    // Assembly state registers advance on each popped item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_first_reg   <= '0;
            held_second_reg  <= '0;
            seen_count_reg   <= '0;
            list_phase_reg   <= '0;
            strip_parity_reg <= 1'b0;
            tally_reg        <= '0;
        end else if (pop) begin
            held_first_reg   <= held_first_next;
            held_second_reg  <= held_second_next;
            seen_count_reg   <= seen_count_next;
            list_phase_reg   <= list_phase_next;
            strip_parity_reg <= strip_parity_next;
            tally_reg        <= tally_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        out_tri_reg   <= out_tri_next;
        out_a_reg     <= out_a_next;
        out_b_reg     <= out_b_next;
        out_c_reg     <= out_c_next;
        out_count_reg <= out_count_next;
        out_end_reg   <= out_end_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_c_reg, out_b_reg, out_a_reg};
    assign m_axis_tuser  = out_tri_reg;
    assign m_axis_tlast  = out_end_reg;

endmodule

// File: src/triangle_primitive_assembler.sv
// Triangle primitive assembler. Vertex indices arrive one per item, are rebased by
// base_index (low INDEX_WIDTH bits of the index plus the base, wrapping at 32 bits)
// and are grouped into triangles as a list, strip or fan according to prim_mode;
// mode 3 forms none. The item marked with tlast ends the set: its result carries
// set_end and the set's triangle count, and all assembly state is cleared. The
// block takes one item per clock while the queue has room; a four-entry queue
// separates the input stage from the assembly stage, so a stalled result channel
// does not stop intake until the queue fills. A result passes through the queue
// and then the result register; items that close no triangle and do not end a set
// produce no result. The user writes configuration via cfg_we/cfg_addr/cfg_wdata
// only while no items are in flight; the block itself does not enforce this.
module triangle_primitive_assembler #(
    parameter int INDEX_WIDTH = tpa_pkg::INDEX_W_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [tpa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tpa_pkg::DATA_W-1:0]        cfg_wdata,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: vertex_index [31:0]
    input  logic [tpa_pkg::DATA_W-1:0]        s_axis_tdata,
    // tlast: set_last
    input  logic                              s_axis_tlast,
    // Result items.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: corner_a [31:0], corner_b [63:32], corner_c [95:64],
    // triangles_so_far [127:96]
    output logic [4*tpa_pkg::DATA_W-1:0]      m_axis_tdata,
    // tuser: tri_valid
    output logic                              m_axis_tuser,
    // tlast: set_end
    output logic                              m_axis_tlast
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    tpa_pkg::q_entry_t q_entry;
    tpa_pkg::q_head_t  q_head;

    // Intake, configuration and rebasing.
    tpa_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    // Queue between intake and assembly.
    tpa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Triangle assembly and result register.
    tpa_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // A result without a triangle only ever reports the end of a set.
    a_empty_result_ends_set: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast
    ) else $error("result without triangle that does not end a set");

    // A result without a triangle carries zero corners.
    a_empty_result_zero_corners: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[95:0] == 96'd0)
    ) else $error("result without triangle carries nonzero corners");

    // Nothing is offered on the result channel right after reset.
    a_reset_clears_output: assert property (
        @(posedge aclk)
        !aresetn |=> !m_axis_tvalid
    ) else $error("result valid after reset");

    // The back only takes an item that the queue holds.
    a_pop_needs_entry: assert property (
        @(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head.valid
    ) else $error("queue popped while empty");
`endif

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W     = tpa_pkg::DATA_W;
    localparam int CFG_ADDR_W = tpa_pkg::CFG_ADDR_W;

    localparam int INDEX_WIDTH = 32;
    localparam logic [DATA_W-1:0] INDEX_MASK =
        (INDEX_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : ((32'd1 << INDEX_WIDTH) - 32'd1);
    localparam int RANDOM_ITEMS   = 1600;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // One index item waiting to be sent.
    typedef struct {
        logic [DATA_W-1:0] vertex;
        logic              last;
    } vertex_item_t;

    // One result item: a triangle and/or the end of a set.
    typedef struct packed {
        logic              tri_valid;
        logic [DATA_W-1:0] corner_a;
        logic [DATA_W-1:0] corner_b;
        logic [DATA_W-1:0] corner_c;
        logic [DATA_W-1:0] tally;
        logic              set_end;
    } tri_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]      cfg_addr = '0;
    logic [DATA_W-1:0]          cfg_wdata = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [DATA_W-1:0]          s_axis_tdata = '0;
    logic                       s_axis_tlast = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [4*DATA_W-1:0]        m_axis_tdata;
    logic                       m_axis_tuser;
    logic                       m_axis_tlast;

    // Index items not yet offered, and results still awaited from the block.
    vertex_item_t index_queue[$];
    tri_result_t  triangle_queue[$];

    // Configuration as the block holds it.
    tpa_pkg::prim_mode_t mode_cfg = tpa_pkg::MODE_LIST;
    logic [DATA_W-1:0]   base_cfg = '0;

    // Assembly state of the predictor.
    logic [DATA_W-1:0] anchor_vtx = '0;
    logic [DATA_W-1:0] recent_vtx = '0;
    logic [1:0]        strip_seen = '0;
    logic [1:0]        list_pos = '0;
    logic              odd_strip = 1'b0;
    logic [DATA_W-1:0] set_tally = '0;

    bit idle_on = 1'b1;
    int send_gap = 0;
    int recv_gap = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int random_items = 0;
    int phase_count = 0;
    int items_sent = 0;
    int triangles_checked = 0;
    int ends_checked = 0;
    int mode_items[4] = '{0, 0, 0, 0};

    always #2 aclk = ~aclk;

    triangle_primitive_assembler #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Rebase one index, advance the assembly state and queue the result it causes.
    task automatic assemble_index(input logic [DATA_W-1:0] raw, input logic last);
        logic [DATA_W-1:0] v;
        logic              closes;
        tri_result_t       r;
        v = (raw & INDEX_MASK) + base_cfg;
        closes = 1'b0;
        r = '0;
        mode_items[mode_cfg]++;
        case (mode_cfg)
            tpa_pkg::MODE_LIST: begin
                if (list_pos == 2'd0) begin
                    anchor_vtx = v;
                    list_pos = 2'd1;
                end else if (list_pos == 2'd1) begin
                    recent_vtx = v;
                    list_pos = 2'd2;
                end else begin
                    closes = 1'b1;
                    r.corner_a = anchor_vtx;
                    r.corner_b = recent_vtx;
                    r.corner_c = v;
                    list_pos = 2'd0;
                end
            end
            tpa_pkg::MODE_STRIP: begin
                if (strip_seen == 2'd0) begin
                    anchor_vtx = v;
                    strip_seen = 2'd1;
                end else if (strip_seen == 2'd1) begin
                    recent_vtx = v;
                    strip_seen = 2'd2;
                end else begin
                    // Odd triangles swap the two older corners to keep the winding.
                    closes = 1'b1;
                    r.corner_a = odd_strip ? recent_vtx : anchor_vtx;
                    r.corner_b = odd_strip ? anchor_vtx : recent_vtx;
                    r.corner_c = v;
                    anchor_vtx = recent_vtx;
                    recent_vtx = v;
                    odd_strip = ~odd_strip;
                end
            end
            tpa_pkg::MODE_FAN: begin
                if (strip_seen == 2'd0) begin
                    anchor_vtx = v;
                    strip_seen = 2'd1;
                end else if (strip_seen == 2'd1) begin
                    recent_vtx = v;
                    strip_seen = 2'd2;
                end else begin
                    closes = 1'b1;
                    r.corner_a = anchor_vtx;
                    r.corner_b = recent_vtx;
                    r.corner_c = v;
                    recent_vtx = v;
                end
            end
            default: begin
            end
        endcase
        if (closes) set_tally = set_tally + 32'd1;
        if (closes || last) begin
            r.tri_valid = closes;
            r.tally = set_tally;
            r.set_end = last;
            triangle_queue = {triangle_queue, r};
        end
        // The last item of a set clears all assembly state.
        if (last) begin
            anchor_vtx = '0;
            recent_vtx = '0;
            strip_seen = '0;
            list_pos = '0;
            odd_strip = 1'b0;
            set_tally = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input tri_result_t want,
                                   input tri_result_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t %s", $realtime, what);
            $display("  expected tri=%0b a=%h b=%h c=%h count=%h end=%0b",
                     want.tri_valid, want.corner_a, want.corner_b, want.corner_c,
                     want.tally, want.set_end);
            $display("  actual   tri=%0b a=%h b=%h c=%h count=%h end=%0b",
                     got.tri_valid, got.corner_a, got.corner_b, got.corner_c,
                     got.tally, got.set_end);
        end
    endtask

    // Driver: offers queued index items, with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                assemble_index(s_axis_tdata, s_axis_tlast);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (index_queue.size() > 0) begin
                    vertex_item_t item;
                    item = index_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= item.vertex;
                    s_axis_tlast <= item.last;
                    send_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls at random and checks each result item against the oldest one awaited.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                tri_result_t got;
                tri_result_t want;
                got.tri_valid = m_axis_tuser;
                got.corner_a = m_axis_tdata[DATA_W-1:0];
                got.corner_b = m_axis_tdata[2*DATA_W-1:DATA_W];
                got.corner_c = m_axis_tdata[3*DATA_W-1:2*DATA_W];
                got.tally = m_axis_tdata[4*DATA_W-1:3*DATA_W];
                got.set_end = m_axis_tlast;
                if (triangle_queue.size() == 0) begin
                    report_mismatch("Result item with nothing awaited", '0, got);
                end else begin
                    want = triangle_queue.pop_front();
                    if (got !== want) begin
                        report_mismatch("Result item mismatch", want, got);
                    end else begin
                        if (want.tri_valid) triangles_checked++;
                        if (want.set_end) ends_checked++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles, %0d results awaited",
                         WATCHDOG_LIMIT, triangle_queue.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input tpa_pkg::cfg_reg_t idx, input logic [DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx == tpa_pkg::REG_PRIM_MODE) mode_cfg = tpa_pkg::prim_mode_t'(val[1:0]);
        else base_cfg = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Waits until every item is sent and every result is in, then lets the pipeline drain.
    task automatic wait_idle();
        do @(negedge aclk);
        while (index_queue.size() != 0 || s_axis_tvalid || triangle_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        phase_count++;
    endtask

    task automatic add_index(input logic [DATA_W-1:0] v, input logic last);
        vertex_item_t item;
        item.vertex = v;
        item.last = last;
        index_queue = {index_queue, item};
    endtask

    // Queues one primitive set of random content; an open set is left without its last item.
    task automatic queue_set(input int len, input bit close);
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] v;
        int                style;
        style = $urandom_range(0, 3);
        start = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8) : $urandom;
        for (int i = 0; i < len; i++) begin
            case (style)
                0: v = start + i;
                1: v = $urandom;
                2: v = $urandom_range(0, 15);
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0000_0000;
                        1: v = 32'hFFFF_FFFF;
                        2: v = 32'h8000_0000;
                        default: v = 32'h7FFF_FFFF;
                    endcase
                end
            endcase
            add_index(v, close && (i == len - 1));
        end
        random_items += len;
    endtask

    initial begin
        int n_sets;
        int len;
        int r;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // List mode at reset settings: one full triangle, then a partial one that is dropped.
        add_index(32'h0000_0000, 1'b0);
        add_index(32'hFFFF_FFFF, 1'b0);
        add_index(32'h1234_5678, 1'b0);
        add_index(32'h0000_0001, 1'b0);
        add_index(32'h0000_0002, 1'b1);
        wait_idle();

        // Strip with a base that wraps, then a strip too short for a triangle.
        write_reg(tpa_pkg::REG_PRIM_MODE, DATA_W'(tpa_pkg::MODE_STRIP));
        write_reg(tpa_pkg::REG_BASE_INDEX, 32'hFFFF_FFFF);
        for (int i = 1; i <= 5; i++) add_index(DATA_W'(i), i == 5);
        add_index(32'h0000_0007, 1'b0);
        add_index(32'h0000_0008, 1'b1);
        wait_idle();

        // Fan around a shared center, then a set of a single index.
        write_reg(tpa_pkg::REG_PRIM_MODE, DATA_W'(tpa_pkg::MODE_FAN));
        write_reg(tpa_pkg::REG_BASE_INDEX, 32'h8000_0000);
        add_index(32'd10, 1'b0);
        add_index(32'd20, 1'b0);
        add_index(32'hFFFF_FFFF, 1'b0);
        add_index(32'd40, 1'b1);
        add_index(32'd50, 1'b1);
        wait_idle();

        // Non-triangle mode only reports the end of the set.
        write_reg(tpa_pkg::REG_PRIM_MODE, DATA_W'(tpa_pkg::MODE_OTHER));
        add_index(32'd5, 1'b0);
        add_index(32'd6, 1'b1);
        wait_idle();

        // A set that starts in list mode and finishes in fan mode.
        write_reg(tpa_pkg::REG_PRIM_MODE, DATA_W'(tpa_pkg::MODE_LIST));
        write_reg(tpa_pkg::REG_BASE_INDEX, 32'h0000_0000);
        add_index(32'd100, 1'b0);
        add_index(32'd101, 1'b0);
        wait_idle();
        write_reg(tpa_pkg::REG_PRIM_MODE, DATA_W'(tpa_pkg::MODE_FAN));
        add_index(32'd102, 1'b0);
        add_index(32'd103, 1'b1);
        wait_idle();

        // Random phases, each with its own settings and idling.
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            write_reg(tpa_pkg::REG_PRIM_MODE,
                      DATA_W'((r < 3) ? tpa_pkg::MODE_LIST : (r < 6) ? tpa_pkg::MODE_STRIP :
                              (r < 9) ? tpa_pkg::MODE_FAN : tpa_pkg::MODE_OTHER));
            case ($urandom_range(0, 4))
                0: write_reg(tpa_pkg::REG_BASE_INDEX, 32'h0000_0000);
                1: write_reg(tpa_pkg::REG_BASE_INDEX, 32'hFFFF_FFFF);
                2: write_reg(tpa_pkg::REG_BASE_INDEX, $urandom);
                3: write_reg(tpa_pkg::REG_BASE_INDEX, 32'hFFFF_FFFF - $urandom_range(0, 20));
                default: write_reg(tpa_pkg::REG_BASE_INDEX, $urandom_range(0, 1000));
            endcase
            idle_on = ($urandom_range(0, 4) != 0);
            n_sets = $urandom_range(2, 12);
            for (int s = 0; s < n_sets; s++) begin
                r = $urandom_range(0, 9);
                len = (r < 6) ? $urandom_range(1, 9) :
                      (r < 9) ? $urandom_range(10, 30) : $urandom_range(31, 80);
                queue_set(len, !(s == n_sets - 1 && $urandom_range(0, 4) == 0));
            end
            wait_idle();
        end

        $display("Sent %0d index items over %0d phases (list %0d, strip %0d, fan %0d, other %0d).",
                 items_sent, phase_count, mode_items[tpa_pkg::MODE_LIST],
                 mode_items[tpa_pkg::MODE_STRIP], mode_items[tpa_pkg::MODE_FAN],
                 mode_items[tpa_pkg::MODE_OTHER]);
        $display("Checked %0d triangles and %0d set ends; %0d mismatches.",
                 triangles_checked, ends_checked, error_count);
        if (error_count == 0 && triangle_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: triangle_primitive_assembler.f
src/tpa_pkg.sv
src/tpa_front.sv
src/tpa_queue.sv
src/tpa_back.sv
src/triangle_primitive_assembler.sv
dv/testbench.sv
